### rtl/rcs_pkg.sv
`default_nettype none

package rcs_pkg;

    // Field widths of the request and response.
    localparam int STATUS_W = 10;
    localparam int SIZE_W   = 40;
    localparam int BUCKET_W = 35;
    localparam int HITS_W   = 32;
    localparam int THRESH_W = 16;
    localparam int DEC_W    = 2;

    // A size bucket is the size divided by 32.
    localparam int BUCKET_SHIFT = 5;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd16;
    localparam logic [HITS_W-1:0]   MAX_HITS     = '1;

    // Decision codes.
    localparam logic [DEC_W-1:0] DEC_PRINT   = 2'd0;
    localparam logic [DEC_W-1:0] DEC_MUTED   = 2'd1;
    localparam logic [DEC_W-1:0] DEC_TRIGGER = 2'd2;

    // Request command codes.
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [STATUS_W-1:0] status_code;
        logic [SIZE_W-1:0]   body_len;
    } t_req;

    typedef struct packed {
        logic [DEC_W-1:0]    decision;
        logic [BUCKET_W-1:0] len_bucket;
        logic [HITS_W-1:0]   hit_count;
        logic                table_full;
    } t_rsp;

    // Cluster key held by each cell.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
    } t_key;

    // Write-back control broadcast to the cell row.
    typedef struct packed {
        logic              clr;
        logic              ins;
        logic              upd;
        t_key              key;
        logic [HITS_W-1:0] hits;
        logic              muted;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/rcs_cell.sv
`default_nettype none

module rcs_cell
    import rcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmp_en,
    input  wire t_key              i_cmp_key,
    input  wire logic              i_prev_occ,
    input  wire t_cell_ctl         i_ctl,
    output logic                   o_occ,
    output logic                   o_match,
    output logic [HITS_W-1:0]      o_hits,
    output logic                   o_muted
);

    logic              r_occ;
    logic              n_occ;
    logic              r_match;
    t_key              r_key;
    logic [HITS_W-1:0] r_hits;
    logic              r_muted;
    logic              w_take;
    logic              w_upd;

    // A new cluster lands in the first free cell: the left neighbor is
    // occupied and this one is not.
    assign w_take = i_ctl.ins & i_prev_occ & ~r_occ;
    assign w_upd  = i_ctl.upd & r_match;

    always_comb begin
        n_occ = r_occ;
        if (i_ctl.clr) begin
            n_occ = 1'b0;
        end else if (w_take) begin
            n_occ = 1'b1;
        end
    end

    // Occupancy and the match flag of the current lookup.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (i_cmp_en) begin
                r_match <= r_occ && (r_key == i_cmp_key);
            end
        end
    end

    // Stored cluster contents.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key <= i_ctl.key;
        end
        if (w_take || w_upd) begin
            r_hits  <= i_ctl.hits;
            r_muted <= i_ctl.muted;
        end
    end

    // Contents are driven only by the matching cell so the row can be OR-merged.
    assign o_occ   = r_occ;
    assign o_match = r_match;
    assign o_hits  = r_match ? r_hits : '0;
    assign o_muted = r_match & r_muted;

endmodule

`default_nettype wire

### rtl/response_cluster_suppressor.sv
// The request is taken into the cell match flags and the state register, and the
// response is registered at the write-back. No new request is taken before that
// write-back; the row of cells compares the key in the accept cycle.
// A stalled response holds the write-back, and with it the next request.
// Reset (synchronous, active low) empties the cluster table and sets the threshold to 16.
`default_nettype none

module response_cluster_suppressor
    import rcs_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    output logic                     o_req_stall,
    input  wire t_req                i_req,
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_stall,
    output t_rsp                     o_rsp,
    input  wire logic                i_cfg_we,
    input  wire logic [THRESH_W-1:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [THRESH_W-1:0] r_thresh;
    logic                r_cmd;
    t_key                r_key;
    logic                r_rsp_valid;
    t_rsp                r_rsp;
    t_rsp                n_rsp;

    logic                w_accept;
    logic                w_commit;
    t_key                w_cmp_key;
    t_cell_ctl           w_ctl;
    logic [ENTRIES-1:0]  w_occ;
    logic [ENTRIES-1:0]  w_prev;
    logic [ENTRIES-1:0]  w_match;
    logic [ENTRIES-1:0]  w_muted;
    logic [HITS_W-1:0]   w_hits [ENTRIES];
    logic [HITS_W-1:0]   w_old_hits;
    logic                w_old_muted;
    logic [HITS_W-1:0]   w_new_hits;
    logic                w_found;
    logic                w_full;
    logic                w_at_thr;
    logic [DEC_W-1:0]    w_decision;

    assign w_accept  = i_req_valid & ~o_req_stall;
    assign w_commit  = (r_state == S_UPDATE) & (~r_rsp_valid | ~i_rsp_stall);
    assign w_cmp_key = '{status: i_req.status_code,
                         bucket: i_req.body_len[SIZE_W-1:BUCKET_SHIFT]};

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // Lookup and write-back sequencing.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);

    // Request held for the write-back cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_req.cmd;
            r_key <= w_cmp_key;
        end
    end

    // Row of cells; occupancy passes from each cell to its right neighbor.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = 1'b1;
        end else begin : g_link
            assign w_prev[g] = w_occ[g-1];
        end

        rcs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmp_en   (w_accept),
            .i_cmp_key  (w_cmp_key),
            .i_prev_occ (w_prev[g]),
            .i_ctl      (w_ctl),
            .o_occ      (w_occ[g]),
            .o_match    (w_match[g]),
            .o_hits     (w_hits[g]),
            .o_muted    (w_muted[g])
        );
    end

    // Merge the matching cell's contents; at most one cell drives them.
    always_comb begin
        w_old_hits = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_old_hits = w_old_hits | w_hits[i];
        end
    end

    assign w_old_muted = |w_muted;
    assign w_found     = |w_match;
    assign w_full      = w_occ[ENTRIES-1];

    // Count update and decision; a new cluster starts from zero.
    assign w_new_hits = (w_old_hits == MAX_HITS) ? w_old_hits : w_old_hits + 1'b1;
    assign w_at_thr   = w_new_hits >= {{(HITS_W-THRESH_W){1'b0}}, r_thresh};

    always_comb begin
        if (w_old_muted) begin
            w_decision = DEC_MUTED;
        end else if (w_at_thr) begin
            w_decision = DEC_TRIGGER;
        end else begin
            w_decision = DEC_PRINT;
        end
    end

    assign w_ctl = '{clr:   w_commit & (r_cmd == CMD_CLEAR),
                     ins:   w_commit & (r_cmd == CMD_CHECK) & ~w_found,
                     upd:   w_commit & (r_cmd == CMD_CHECK) & w_found,
                     key:   r_key,
                     hits:  w_new_hits,
                     muted: w_old_muted | w_at_thr};

    // Response contents.
    always_comb begin
        if (r_cmd == CMD_CLEAR) begin
            n_rsp = '0;
        end else if (!w_found && w_full) begin
            n_rsp = '{decision:    DEC_PRINT,
                      len_bucket:  r_key.bucket,
                      hit_count:   HITS_W'(1),
                      table_full:  1'b1};
        end else begin
            n_rsp = '{decision:    w_decision,
                      len_bucket:  r_key.bucket,
                      hit_count:   w_new_hits,
                      table_full:  1'b0};
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_commit) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Keys are unique among occupied cells, so a lookup hits at most one cell.
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> $onehot0(w_match))
        else $error("more than one cell matched the lookup key");

    // Occupied cells always form a contiguous run starting at the first cell.
    a_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ & ~w_prev) == '0))
        else $error("occupancy has a gap in the cell row");

    // A taken request enters the write-back state in the next cycle.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_UPDATE))
        else $error("accepted request did not enter write-back");

    // A rejected new key is always reported as a print with a count of one.
    a_full_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.table_full) |->
            (o_rsp.decision == DEC_PRINT && o_rsp.hit_count == HITS_W'(1)))
        else $error("table full response has wrong decision or count");

endmodule

`default_nettype wire

### sim/response_cluster_suppressor_tb.sv
`default_nettype none

module response_cluster_suppressor_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rcs_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int POOL_MAX     = 128;

    // Cluster table mirror and the queue of responses it predicts.
    class cluster_scoreboard;
        logic [THRESH_W-1:0] thresh;
        logic [STATUS_W-1:0] tbl_status [TABLE_DEPTH];
        logic [BUCKET_W-1:0] tbl_bucket [TABLE_DEPTH];
        logic [HITS_W-1:0]   tbl_hits   [TABLE_DEPTH];
        logic                tbl_muted  [TABLE_DEPTH];
        int                  used;
        t_rsp                expected_rsp [$];
        int                  error_count;

        function new();
            thresh      = THRESH_RESET;
            used        = 0;
            error_count = 0;
        endfunction

        // Work out the response that an accepted request will produce.
        function void note_request(t_req r);
            t_rsp                rsp;
            logic [BUCKET_W-1:0] bkt;
            int                  slot;
            rsp = '0;
            if (r.cmd == CMD_CLEAR) begin
                used = 0;
                expected_rsp.push_back(rsp);
                return;
            end
            bkt = BUCKET_W'(r.body_len >> BUCKET_SHIFT);
            rsp.len_bucket = bkt;
            slot = -1;
            for (int i = 0; i < used; i++) begin
                if (slot < 0 && tbl_status[i] == r.status_code && tbl_bucket[i] == bkt) begin
                    slot = i;
                end
            end
            // A new key on a full table is reported but never stored.
            if (slot < 0 && used >= TABLE_DEPTH) begin
                rsp.decision   = DEC_PRINT;
                rsp.hit_count  = HITS_W'(1);
                rsp.table_full = 1'b1;
                expected_rsp.push_back(rsp);
                return;
            end
            if (slot < 0) begin
                slot = used;
                used++;
                tbl_status[slot] = r.status_code;
                tbl_bucket[slot] = bkt;
                tbl_hits[slot]   = '0;
                tbl_muted[slot]  = 1'b0;
            end
            if (tbl_hits[slot] != MAX_HITS) begin
                tbl_hits[slot] = tbl_hits[slot] + 1'b1;
            end
            if (tbl_muted[slot]) begin
                rsp.decision = DEC_MUTED;
            end else if (tbl_hits[slot] >= HITS_W'(thresh)) begin
                tbl_muted[slot] = 1'b1;
                rsp.decision    = DEC_TRIGGER;
            end else begin
                rsp.decision = DEC_PRINT;
            end
            rsp.hit_count = tbl_hits[slot];
            expected_rsp.push_back(rsp);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            error_count++;
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
            end
        endtask

        // Compare an accepted response with the oldest prediction.
        task check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                report_mismatch("response arrived with no request pending");
                return;
            end
            want = expected_rsp.pop_front();
            check_field("decision", 64'(got.decision), 64'(want.decision));
            check_field("len_bucket", 64'(got.len_bucket), 64'(want.len_bucket));
            check_field("hit_count", 64'(got.hit_count), 64'(want.hit_count));
            check_field("table_full", 64'(got.table_full), 64'(want.table_full));
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                req_valid   = 1'b0;
    t_req                req_bus     = '0;
    logic                rsp_stall   = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [THRESH_W-1:0] cfg_wdata   = '0;
    logic                o_req_stall;
    logic                o_rsp_valid;
    t_rsp                o_rsp;

    int                  cycle_count = 0;
    int                  burst_left  = 1;
    logic [STATUS_W-1:0] pool_status [POOL_MAX];
    logic [BUCKET_W-1:0] pool_bucket [POOL_MAX];

    cluster_scoreboard sb = new();

    response_cluster_suppressor #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (req_bus),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (o_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Response side: check accepted responses and stall in shifting modes.
    always @(posedge i_clk) begin
        if (o_rsp_valid && !rsp_stall) begin
            sb.check_response(o_rsp);
        end
        case (cycle_count[8:7])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= (cycle_count[2:0] < 3);
        endcase
    end

    function automatic t_req check_req(logic [STATUS_W-1:0] code, logic [SIZE_W-1:0] size);
        t_req r;
        r.cmd         = CMD_CHECK;
        r.status_code = code;
        r.body_len    = size;
        return r;
    endfunction

    // Present one request, wait for it to be taken, then pace the sender in bursts.
    task automatic issue_request(t_req r);
        int gap;
        req_valid <= 1'b1;
        req_bus   <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        sb.note_request(r);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Change the threshold once every pending response has come back.
    task automatic write_threshold(logic [THRESH_W-1:0] value);
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.thresh = value;
    endtask

    // One random phase: a threshold, a fresh table and requests, most drawn from a key pool.
    task automatic run_phase(logic [THRESH_W-1:0] thr, int pool_n, int count, int clear_pct);
        t_req r;
        int   roll;
        int   k;
        write_threshold(thr);
        for (int i = 0; i < pool_n; i++) begin
            pool_status[i] = STATUS_W'($urandom_range(0, 1023));
            pool_bucket[i] = $urandom_range(0, 1) ? BUCKET_W'({$urandom, $urandom})
                                                  : BUCKET_W'($urandom_range(0, 7));
        end
        r.cmd         = CMD_CLEAR;
        r.status_code = STATUS_W'($urandom_range(0, 1023));
        r.body_len    = SIZE_W'({$urandom, $urandom});
        issue_request(r);
        for (int n = 0; n < count; n++) begin
            roll          = $urandom_range(0, 99);
            r.cmd         = (roll < clear_pct) ? CMD_CLEAR : CMD_CHECK;
            r.status_code = STATUS_W'($urandom_range(0, 1023));
            r.body_len    = SIZE_W'({$urandom, $urandom});
            // Most checks reuse pool keys so that clusters build up and trigger.
            if (roll >= clear_pct + 10) begin
                k             = $urandom_range(0, pool_n - 1);
                r.status_code = pool_status[k];
                r.body_len    = {pool_bucket[k], 5'($urandom)};
            end
            issue_request(r);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clear with a busy payload, field extremes, shared buckets.
        issue_request('{cmd: CMD_CLEAR, status_code: '1, body_len: '1});
        issue_request(check_req(10'd0, 40'd0));
        issue_request(check_req(10'h3FF, 40'hFF_FFFF_FFFF));
        issue_request(check_req(10'd999, 40'd31));
        issue_request(check_req(10'd0, 40'd31));
        issue_request(check_req(10'd1000, 40'd32));

        // Threshold of one: first hit triggers, the next one is muted.
        write_threshold(16'd1);
        issue_request(check_req(10'd500, 40'h12_3456_7890));
        issue_request(check_req(10'd500, 40'h12_3456_789F));
        issue_request(check_req(10'd0, 40'd0));

        // Threshold of zero triggers on any unmarked cluster.
        write_threshold(16'd0);
        issue_request(check_req(10'd7, 40'h80_0000_0000));

        // Count up to a small threshold and past it.
        write_threshold(16'd3);
        repeat (4) issue_request(check_req(10'd404, 40'd4096));

        // Largest threshold, then a clear drops every cluster.
        write_threshold(16'hFFFF);
        issue_request(check_req(10'd200, 40'h55_5555_5555));
        issue_request('{cmd: CMD_CLEAR, status_code: '0, body_len: '0});
        issue_request(check_req(10'd0, 40'd0));

        // Random phases; the large pools overflow the table.
        run_phase(16'd16, 4, 80, 3);
        run_phase(16'd1, 100, 120, 0);
        run_phase(16'd2, 6, 60, 5);
        run_phase(16'hFFFF, 120, 100, 0);
        run_phase(THRESH_W'($urandom_range(1, 8)), 3, 60, 4);
        run_phase(16'd0, 8, 30, 5);

        // Drain outstanding responses, then let the block settle.
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_rsp.size() != 0) begin
            sb.report_mismatch("responses still pending at the end");
        end
        if (sb.error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/rcs_pkg.sv
rtl/rcs_cell.sv
rtl/response_cluster_suppressor.sv
sim/response_cluster_suppressor_tb.sv
